### hw/rtl/prq_pkg.sv
// ============================================================================
// prq_pkg - shared types and constants of the priority ready queue scheduler
// Holds the sizing constants, the command and response payloads, the
// sequencer states and the request/response bundles of the link store.
// ============================================================================
package prq_pkg;

  // sizing
  localparam int unsigned PRIORITY_LEVELS = 32;
  localparam int unsigned THREAD_SLOTS    = 64;
  localparam int unsigned LEVEL_W         = $clog2(PRIORITY_LEVELS);
  localparam int unsigned SLOT_W          = $clog2(THREAD_SLOTS);
  localparam int unsigned LOCK_W          = 16;

  // operation codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SCHED  = 3'd2,
    OP_START  = 3'd3,
    OP_ENTER  = 3'd4,
    OP_EXIT   = 3'd5
  } op_e_t;

  // command payload
  typedef struct packed {
    logic [2:0] op;
    logic [5:0] thread_id;
    logic [4:0] priority_req;
  } cmd_t;

  // response payload
  typedef struct packed {
    logic [5:0]  running_thread;
    logic [4:0]  running_priority;
    logic        switched;
    logic        started;
    logic [15:0] lock_level;
    logic        none_ready;
  } rsp_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;

  // link store request: one read set and one write per memory
  typedef struct packed {
    logic               rd_en;
    logic [LEVEL_W-1:0] head_raddr;
    logic [LEVEL_W-1:0] tail_raddr;
    logic [SLOT_W-1:0]  slot_raddr;
    logic               head_we;
    logic [LEVEL_W-1:0] head_waddr;
    logic [SLOT_W-1:0]  head_wdata;
    logic               tail_we;
    logic [LEVEL_W-1:0] tail_waddr;
    logic [SLOT_W-1:0]  tail_wdata;
    logic               next_we;
    logic [SLOT_W-1:0]  next_waddr;
    logic [SLOT_W-1:0]  next_wdata;
    logic               prev_we;
    logic [SLOT_W-1:0]  prev_waddr;
    logic [SLOT_W-1:0]  prev_wdata;
  } link_req_t;

  // link store registered read data
  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] next;
    logic [SLOT_W-1:0] prev;
  } link_rsp_t;

endpackage

### hw/rtl/prq_ffs.sv
// ============================================================================
// prq_ffs - find-first-set over the ready bitmap
// Returns the lowest-numbered set level and whether any level is set.
// ============================================================================
module prq_ffs (
  input  logic [prq_pkg::PRIORITY_LEVELS-1:0] mask,
  output logic                                found,
  output logic [prq_pkg::LEVEL_W-1:0]         level
);
  import prq_pkg::*;

  // priority encoder, lowest index wins
  always_comb begin
    found = |mask;
    level = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        level = LEVEL_W'(i);
      end
    end
  end

endmodule

### hw/rtl/prq_links.sv
// ============================================================================
// prq_links - queue head/tail and thread link memories
// Four single-write, single-read memories with registered read data.
// ============================================================================
module prq_links (
  input  logic                clk,
  input  prq_pkg::link_req_t  req,
  output prq_pkg::link_rsp_t  rd
);
  import prq_pkg::*;

  logic [SLOT_W-1:0] head_mem [PRIORITY_LEVELS];
  logic [SLOT_W-1:0] tail_mem [PRIORITY_LEVELS];
  logic [SLOT_W-1:0] next_mem [THREAD_SLOTS];
  logic [SLOT_W-1:0] prev_mem [THREAD_SLOTS];

  // writes
  always_ff @(posedge clk) begin
    if (req.head_we) head_mem[req.head_waddr] <= req.head_wdata;
    if (req.tail_we) tail_mem[req.tail_waddr] <= req.tail_wdata;
    if (req.next_we) next_mem[req.next_waddr] <= req.next_wdata;
    if (req.prev_we) prev_mem[req.prev_waddr] <= req.prev_wdata;
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd.head <= head_mem[req.head_raddr];
      rd.tail <= tail_mem[req.tail_raddr];
      rd.next <= next_mem[req.slot_raddr];
      rd.prev <= prev_mem[req.slot_raddr];
    end
  end

endmodule

### hw/rtl/priority_ready_queue_scheduler_unit.sv
// ============================================================================
// priority_ready_queue_scheduler_unit - bitmap ready queue thread scheduler
// Per-level FIFOs as doubly linked lists, a ready bitmap, find-first-set
// selection of the next thread and a scheduler lock count.
// ============================================================================
//
//  channel | signals                 | role
//  --------+-------------------------+------------------------------------
//  cmd     | cmd_valid, cmd_stall,cmd| one operation per transfer
//  rsp     | rsp_valid, rsp_stall,rsp| one result per operation
//
//  Each command passes through accept, link/head read with bitmap search,
//  update and response load. The registered read of the link memories sets
//  the read-then-write sequence of every operation.
//  A new command is taken while the previous response still waits.
//  Synchronous active-high reset clears the bitmap, running thread and lock
//  count; link memories need no clearing.
//
module priority_ready_queue_scheduler_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  prq_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output prq_pkg::rsp_t  rsp
);
  import prq_pkg::*;

  state_t                     state, state_next;
  cmd_t                       item;
  logic [PRIORITY_LEVELS-1:0] ready_mask, ready_mask_next;
  logic [SLOT_W-1:0]          cur_thread, cur_thread_next;
  logic                       cur_valid, cur_valid_next;
  logic [LEVEL_W-1:0]         cur_level, cur_level_next;
  logic [LOCK_W-1:0]          lock_nest, lock_nest_next;
  logic                       pick_found;
  logic [LEVEL_W-1:0]         pick_level;
  logic                       sw, sw_next;
  logic                       none, none_next;

  logic                       ffs_found;
  logic [LEVEL_W-1:0]         ffs_level;
  link_req_t                  lreq;
  link_rsp_t                  lrd;

  logic [SLOT_W-1:0]          tid_s;
  logic [LEVEL_W-1:0]         pri_l;
  logic                       args_ok;
  logic                       level_set;
  logic                       is_pick_op;
  logic                       do_pick;
  logic [LOCK_W-1:0]          lock_dec;
  logic                       rsp_free;
  logic                       is_head, is_tail;

  // bitmap search
  prq_ffs u_ffs (
    .mask  (ready_mask),
    .found (ffs_found),
    .level (ffs_level)
  );

  // link memories
  prq_links u_links (
    .clk (clk),
    .req (lreq),
    .rd  (lrd)
  );

  // decoded command fields
  assign tid_s     = SLOT_W'(item.thread_id);
  assign pri_l     = LEVEL_W'(item.priority_req);
  assign args_ok   = (32'(item.thread_id) < THREAD_SLOTS) &&
                     (32'(item.priority_req) < PRIORITY_LEVELS);
  assign level_set = ready_mask[pri_l];
  assign is_pick_op = (item.op == OP_SCHED) || (item.op == OP_START) ||
                      (item.op == OP_EXIT);
  assign lock_dec  = (lock_nest != '0) ? lock_nest - LOCK_W'(1) : lock_nest;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign is_head   = (lrd.head == tid_s);
  assign is_tail   = (lrd.tail == tid_s);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_DONE;
      ST_DONE: if (rsp_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and update datapath
  always_comb begin
    cmd_stall       = (state != ST_IDLE);
    lreq            = '0;
    ready_mask_next = ready_mask;
    cur_thread_next = cur_thread;
    cur_valid_next  = cur_valid;
    cur_level_next  = cur_level;
    lock_nest_next  = lock_nest;
    sw_next         = sw;
    none_next       = none;
    do_pick         = 1'b0;

    unique case (state)
      ST_READ: begin
        lreq.rd_en      = 1'b1;
        lreq.head_raddr = is_pick_op ? ffs_level : pri_l;
        lreq.tail_raddr = pri_l;
        lreq.slot_raddr = tid_s;
      end
      ST_EXEC: begin
        sw_next   = 1'b0;
        none_next = 1'b0;
        unique case (op_e_t'(item.op))
          OP_INSERT: begin
            if (args_ok) begin
              if (!level_set) begin
                lreq.head_we    = 1'b1;
                lreq.head_waddr = pri_l;
                lreq.head_wdata = tid_s;
              end else begin
                lreq.next_we    = 1'b1;
                lreq.next_waddr = lrd.tail;
                lreq.next_wdata = tid_s;
                lreq.prev_we    = 1'b1;
                lreq.prev_waddr = tid_s;
                lreq.prev_wdata = lrd.tail;
              end
              lreq.tail_we           = 1'b1;
              lreq.tail_waddr        = pri_l;
              lreq.tail_wdata        = tid_s;
              ready_mask_next[pri_l] = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (args_ok && level_set) begin
              priority if (is_head && is_tail) begin
                ready_mask_next[pri_l] = 1'b0;
              end else if (is_head) begin
                lreq.head_we    = 1'b1;
                lreq.head_waddr = pri_l;
                lreq.head_wdata = lrd.next;
              end else if (is_tail) begin
                lreq.tail_we    = 1'b1;
                lreq.tail_waddr = pri_l;
                lreq.tail_wdata = lrd.prev;
              end else begin
                lreq.next_we    = 1'b1;
                lreq.next_waddr = lrd.prev;
                lreq.next_wdata = lrd.next;
                lreq.prev_we    = 1'b1;
                lreq.prev_waddr = lrd.next;
                lreq.prev_wdata = lrd.prev;
              end
            end
          end
          OP_SCHED: do_pick = (lock_nest == '0);
          OP_START: do_pick = 1'b1;
          OP_ENTER: begin
            if (lock_nest != '1) lock_nest_next = lock_nest + LOCK_W'(1);
          end
          OP_EXIT: begin
            lock_nest_next = lock_dec;
            do_pick        = (lock_dec == '0) && cur_valid;
          end
          default: ;
        endcase

        // pick the head of the lowest ready level
        if (do_pick) begin
          if (!pick_found) begin
            none_next = 1'b1;
          end else if (!(cur_valid && lrd.head == cur_thread)) begin
            cur_thread_next = lrd.head;
            cur_level_next  = pick_level;
            cur_valid_next  = 1'b1;
            sw_next         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // control and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ready_mask <= '0;
      cur_thread <= '0;
      cur_valid  <= 1'b0;
      cur_level  <= LEVEL_W'(PRIORITY_LEVELS - 1);
      lock_nest  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ready_mask <= ready_mask_next;
      cur_thread <= cur_thread_next;
      cur_valid  <= cur_valid_next;
      cur_level  <= cur_level_next;
      lock_nest  <= lock_nest_next;
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command capture, search result and response payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) item <= cmd;
    if (state == ST_READ) begin
      pick_found <= ffs_found;
      pick_level <= ffs_level;
    end
    sw   <= sw_next;
    none <= none_next;
    if (state == ST_DONE && rsp_free) begin
      rsp.running_thread   <= 6'(cur_thread);
      rsp.running_priority <= 5'(cur_level);
      rsp.switched         <= sw;
      rsp.started          <= cur_valid;
      rsp.lock_level       <= lock_nest;
      rsp.none_ready       <= none;
    end
  end

endmodule

### hw/rtl/prq_checker.sv
// ============================================================================
// prq_checker - port-level checks of the scheduler
// Watches the command and response channels of the top level.
// ============================================================================
module prq_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input prq_pkg::cmd_t  cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input prq_pkg::rsp_t  rsp
);
  import prq_pkg::*;

  // a stalled command holds
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("stalled command changed");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while busy");

  // a switch only happens onto a started scheduler
  a_sw_started: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rsp.switched || rsp.started)
    else $error("switch reported before start");

  // empty bitmap never reports a switch
  a_none_sw: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.switched && rsp.none_ready))
    else $error("switch with empty bitmap");

endmodule

bind priority_ready_queue_scheduler_unit prq_checker u_prq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### sim/tb_priority_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_priority_ready_queue_scheduler_unit - ready queue scheduler testbench
// Drives operations over the cmd channel and checks every response against
// a local prediction of the ready bitmap, the per-level linked lists, the
// running thread and the lock count. Directed cases come first, then random
// well-formed traffic mixed with noise, then deep lock nesting.
// ============================================================================
module tb_priority_ready_queue_scheduler_unit;
  import prq_pkg::*;

  // spare op codes, expected to change nothing
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int WATCHDOG_LIMIT     = 1000;
  localparam int RANDOM_ITEMS       = 1900;
  localparam int LOCK_DEPTH_MAX     = 40;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  // no idling on either side while set
  logic calm = 1'b0;

  int   mismatches  = 0;
  int   idle_cycles = 0;
  rsp_t expected_rsps[$];

  // predicted scheduler state
  logic [PRIORITY_LEVELS-1:0] level_ready = '0;
  logic [SLOT_W-1:0]          level_head [PRIORITY_LEVELS] = '{default: '0};
  logic [SLOT_W-1:0]          level_tail [PRIORITY_LEVELS] = '{default: '0};
  logic [SLOT_W-1:0]          succ_slot  [THREAD_SLOTS]    = '{default: '0};
  logic [SLOT_W-1:0]          pred_slot  [THREAD_SLOTS]    = '{default: '0};
  logic                       succ_written [THREAD_SLOTS]  = '{default: 1'b0};
  logic                       pred_written [THREAD_SLOTS]  = '{default: 1'b0};
  logic [SLOT_W-1:0]          run_thread = '0;
  logic [LEVEL_W-1:0]         run_level  = LEVEL_W'(PRIORITY_LEVELS - 1);
  logic                       run_valid  = 1'b0;
  logic [LOCK_W-1:0]          lock_depth = '0;
  // level each slot was last queued at, -1 when idle; steers random traffic
  int                         slot_level [THREAD_SLOTS]    = '{default: -1};

  priority_ready_queue_scheduler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // head of the lowest-numbered ready level becomes the running thread
  task automatic pick_head(output logic sw, output logic none);
    int lvl;
    lvl  = -1;
    sw   = 1'b0;
    none = 1'b0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (level_ready[i]) lvl = i;
    end
    if (lvl < 0) begin
      none = 1'b1;
    end else if (!(run_valid && level_head[lvl] == run_thread)) begin
      run_thread = level_head[lvl];
      run_level  = LEVEL_W'(lvl);
      run_valid  = 1'b1;
      sw         = 1'b1;
    end
  endtask

  // apply one operation to the predicted state and form its response
  task automatic predict_result(input cmd_t c, output rsp_t r);
    logic               sw;
    logic               none;
    logic               at_head;
    logic               at_tail;
    logic [SLOT_W-1:0]  t;
    logic [LEVEL_W-1:0] p;
    logic [SLOT_W-1:0]  a;
    logic [SLOT_W-1:0]  b;
    sw   = 1'b0;
    none = 1'b0;
    t    = c.thread_id;
    p    = c.priority_req;
    case (c.op)
      OP_INSERT: begin
        // append at the tail, linking behind the old tail if any
        if (level_ready[p]) begin
          a               = level_tail[p];
          succ_slot[a]    = t;
          pred_slot[t]    = a;
          succ_written[a] = 1'b1;
          pred_written[t] = 1'b1;
        end else begin
          level_head[p] = t;
        end
        level_tail[p]  = t;
        level_ready[p] = 1'b1;
        slot_level[t]  = p;
      end
      OP_REMOVE: begin
        if (level_ready[p]) begin
          at_head = (level_head[p] == t);
          at_tail = (level_tail[p] == t);
          if (at_head && at_tail) begin
            level_ready[p] = 1'b0;
          end else if (at_head) begin
            level_head[p] = succ_slot[t];
          end else if (at_tail) begin
            level_tail[p] = pred_slot[t];
          end else begin
            a               = pred_slot[t];
            b               = succ_slot[t];
            succ_slot[a]    = b;
            pred_slot[b]    = a;
            succ_written[a] = 1'b1;
            pred_written[b] = 1'b1;
          end
          if (slot_level[t] == int'(p)) slot_level[t] = -1;
        end
      end
      OP_SCHED: begin
        if (lock_depth == '0) pick_head(sw, none);
      end
      OP_START: begin
        pick_head(sw, none);
      end
      OP_ENTER: begin
        if (lock_depth != '1) lock_depth = lock_depth + 1'b1;
      end
      OP_EXIT: begin
        if (lock_depth != '0) lock_depth = lock_depth - 1'b1;
        if (lock_depth == '0 && run_valid) pick_head(sw, none);
      end
      default: begin
      end
    endcase
    r.running_thread   = run_thread;
    r.running_priority = run_level;
    r.switched         = sw;
    r.started          = run_valid;
    r.lock_level       = lock_depth;
    r.none_ready       = none;
  endtask

  // true when a remove would follow a link that was never written
  function automatic logic follows_unwritten_link(input cmd_t c);
    logic at_head;
    logic at_tail;
    if (c.op != OP_REMOVE || !level_ready[c.priority_req]) return 1'b0;
    at_head = (level_head[c.priority_req] == c.thread_id);
    at_tail = (level_tail[c.priority_req] == c.thread_id);
    if (at_head && at_tail) return 1'b0;
    if (at_head) return !succ_written[c.thread_id];
    if (at_tail) return !pred_written[c.thread_id];
    return !(succ_written[c.thread_id] && pred_written[c.thread_id]);
  endfunction

  // one cmd transfer, with a random gap in front; prediction on acceptance
  task automatic send_cmd(input logic [2:0] op, input logic [SLOT_W-1:0] tid,
                          input logic [LEVEL_W-1:0] pri);
    cmd_t c;
    rsp_t r;
    c.op           = op;
    c.thread_id    = tid;
    c.priority_req = pri;
    if (!calm && $urandom_range(99) < 7) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 7);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    predict_result(c, r);
    expected_rsps.push_back(r);
  endtask

  // schedule and start with nothing ready, exit before start, spare codes, remove from an empty level
  task automatic test_no_ready_threads();
    send_cmd(OP_SCHED, '0, '0);
    send_cmd(OP_START, '1, '1);
    send_cmd(OP_EXIT, '0, '0);
    send_cmd(OP_SPARE_6, '1, '1);
    send_cmd(OP_SPARE_7, '0, '0);
    send_cmd(OP_REMOVE, 6'd5, 5'd5);
  endtask

  // queue building and unlinking at head, middle and tail
  task automatic test_queue_links();
    send_cmd(OP_INSERT, 6'd63, 5'd31);
    send_cmd(OP_INSERT, 6'd42, 5'd31);
    send_cmd(OP_INSERT, 6'd21, 5'd31);
    send_cmd(OP_SCHED, '0, '0);
    send_cmd(OP_START, '0, '0);
    send_cmd(OP_INSERT, 6'd0, 5'd0);
    send_cmd(OP_SCHED, '0, '0);
    send_cmd(OP_INSERT, 6'd7, 5'd3);
    send_cmd(OP_INSERT, 6'd9, 5'd3);
    send_cmd(OP_INSERT, 6'd11, 5'd3);
    send_cmd(OP_REMOVE, 6'd9, 5'd3);
    send_cmd(OP_REMOVE, 6'd11, 5'd3);
    send_cmd(OP_REMOVE, 6'd63, 5'd31);
    send_cmd(OP_REMOVE, 6'd0, 5'd0);
    send_cmd(OP_SCHED, '0, '0);
    // insert of a slot already queued, then empty the level again
    send_cmd(OP_INSERT, 6'd7, 5'd3);
    send_cmd(OP_REMOVE, 6'd7, 5'd3);
    send_cmd(OP_SCHED, '0, '0);
  endtask

  // scheduling held off by the lock, start ignoring it, exit rescheduling
  task automatic test_lock_nesting();
    send_cmd(OP_ENTER, '0, '0);
    send_cmd(OP_ENTER, '0, '0);
    send_cmd(OP_INSERT, 6'd1, 5'd0);
    send_cmd(OP_SCHED, '0, '0);
    send_cmd(OP_EXIT, '0, '0);
    send_cmd(OP_START, '0, '0);
    send_cmd(OP_INSERT, 6'd2, 5'd0);
    send_cmd(OP_REMOVE, 6'd1, 5'd0);
    send_cmd(OP_EXIT, '0, '0);
    send_cmd(OP_EXIT, '0, '0);
  endtask

  // mostly well-formed inserts and removes of tracked slots, some noise
  task automatic test_random_traffic();
    cmd_t c;
    int   roll;
    int   base;
    int   idx;
    logic want_queued;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1100);
      do begin
        c.op           = OP_SCHED;
        c.thread_id    = SLOT_W'($urandom_range(THREAD_SLOTS - 1));
        c.priority_req = LEVEL_W'($urandom_range(PRIORITY_LEVELS - 1));
        roll           = $urandom_range(99);
        if (roll < 9) begin
          c.op = 3'($urandom_range(7));
        end else if (roll < 65) begin
          // insert picks an idle slot, remove a queued one at its level
          want_queued = (roll >= 37);
          base        = $urandom_range(THREAD_SLOTS - 1);
          idx         = -1;
          for (int k = 0; k < THREAD_SLOTS; k++) begin
            if (idx < 0 && ((slot_level[(base + k) % THREAD_SLOTS] >= 0) == want_queued))
              idx = (base + k) % THREAD_SLOTS;
          end
          if (idx >= 0) begin
            c.thread_id = SLOT_W'(idx);
            if (want_queued) begin
              c.op           = OP_REMOVE;
              c.priority_req = LEVEL_W'(slot_level[idx]);
            end else begin
              c.op = OP_INSERT;
              // crowd a few levels so queues grow long
              if ($urandom_range(1)) c.priority_req = LEVEL_W'($urandom_range(3));
            end
          end
        end else if (roll < 80) begin
          c.op = OP_SCHED;
        end else if (roll < 85) begin
          c.op = OP_START;
        end else if (roll < 93) begin
          c.op = (lock_depth < 3) ? OP_ENTER : OP_EXIT;
        end else begin
          c.op = OP_EXIT;
        end
      end while (follows_unwritten_link(c));
      send_cmd(c.op, c.thread_id, c.priority_req);
    end
    calm = 1'b0;
  endtask

  // nest the lock deeply, then unwind it back to zero with a reschedule
  task automatic test_deep_lock_nesting();
    for (int n = 0; n < LOCK_DEPTH_MAX; n++) begin
      send_cmd(OP_ENTER, SLOT_W'(n), LEVEL_W'(n));
    end
    send_cmd(OP_SCHED, '0, '0);
    for (int n = 0; n < LOCK_DEPTH_MAX; n++) begin
      send_cmd(OP_EXIT, '0, '0);
    end
    send_cmd(OP_SCHED, '0, '0);
    send_cmd(OP_ENTER, '1, '1);
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_no_ready_threads();
    test_queue_links();
    test_lock_nesting();
    test_random_traffic();
    test_deep_lock_nesting();
    cmd_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // response side stall
  always @(posedge clk) begin
    rsp_stall <= !rst && !calm && ($urandom_range(99) < 7);
  end

  // compare each response transfer with the oldest prediction
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response transfer: %p", rsp);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp.running_thread !== exp_rsp.running_thread ||
            rsp.running_priority !== exp_rsp.running_priority ||
            rsp.switched !== exp_rsp.switched ||
            rsp.started !== exp_rsp.started ||
            rsp.lock_level !== exp_rsp.lock_level ||
            rsp.none_ready !== exp_rsp.none_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rsp mismatch exp/got: thread %0d/%0d prio %0d/%0d sw %b/%b",
                     exp_rsp.running_thread, rsp.running_thread,
                     exp_rsp.running_priority, rsp.running_priority,
                     exp_rsp.switched, rsp.switched,
                     "  started %b/%b lock %0d/%0d none %b/%b",
                     exp_rsp.started, rsp.started, exp_rsp.lock_level, rsp.lock_level,
                     exp_rsp.none_ready, rsp.none_ready);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
